>>> hw/rtl/status_led_blink_encoder_macros.svh
// ----------------------------------------------------------------------------
// status_led_blink_encoder assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_BLINK_ENCODER_MACROS_SVH
`define STATUS_LED_BLINK_ENCODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SLBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SLBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/slbe_pkg.sv
// ----------------------------------------------------------------------------
// slbe_pkg
// Types, constants and helpers shared by the status LED encoder modules.
// ----------------------------------------------------------------------------
package slbe_pkg;

  localparam int BITS_PER_FRAME = 24;
  localparam int BIT_CNT_W      = $clog2(BITS_PER_FRAME);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int PULSE_W        = 4;
  localparam int CFG_INDEX_W    = 4;
  localparam int INTERVAL_W     = 16;

  localparam logic [PULSE_W-1:0] LONG_PULSE_RESET  = 4'd8;
  localparam logic [PULSE_W-1:0] SHORT_PULSE_RESET = 4'd4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PULSE  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_PULSE = 4'd1;

  typedef enum logic [1:0] {
    CMD_SOLID       = 2'd0,
    CMD_BLINK_START = 2'd1,
    CMD_BLINK_END   = 2'd2,
    CMD_TICK        = 2'd3
  } cmd_t;

  typedef logic [23:0] color_t;

  // frame request from the command front to the frame queue
  typedef struct packed {
    logic   valid;
    color_t grb;
  } frame_req_t;

  // packed red/green/blue to green/red/blue wire order
  function automatic color_t rgb_to_grb(input color_t rgb);
    return {rgb[15:8], rgb[23:16], rgb[7:0]};
  endfunction

  // a zero pulse setting still lasts one tick
  function automatic logic [PULSE_W-1:0] clamp_pulse(input logic [PULSE_W-1:0] v);
    return (v == '0) ? PULSE_W'(1) : v;
  endfunction

endpackage

>>> hw/rtl/slbe_front.sv
// ----------------------------------------------------------------------------
// slbe_front
// Command decoder holding solid, blink and snapshot state; one request per
// accepted cycle, emitting a frame request for commands that send a frame.
// ----------------------------------------------------------------------------
module slbe_front import slbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [1:0]            command,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic [INTERVAL_W-1:0] blink_interval,
  output frame_req_t            frame_req
);

  logic                  blink_active, blink_active_next;
  logic                  phase_on, phase_on_next;
  color_t                solid_color, solid_color_next;
  color_t                flash_color, flash_color_next;
  logic [INTERVAL_W-1:0] flash_interval, flash_interval_next;
  logic [INTERVAL_W-1:0] elapsed_ms, elapsed_ms_next;
  logic                  snap_valid, snap_valid_next;
  logic                  snap_blinking, snap_blinking_next;
  logic [INTERVAL_W-1:0] snap_interval, snap_interval_next;
  color_t                snap_color, snap_color_next;

  color_t                in_color;
  logic [INTERVAL_W-1:0] elapsed_inc;
  logic                  send;
  color_t                send_color;

  assign in_color    = {red, green, blue};
  assign elapsed_inc = (elapsed_ms == '1) ? elapsed_ms : elapsed_ms + INTERVAL_W'(1);

  // command decode and state update
  always_comb begin
    blink_active_next   = blink_active;
    phase_on_next       = phase_on;
    solid_color_next    = solid_color;
    flash_color_next    = flash_color;
    flash_interval_next = flash_interval;
    elapsed_ms_next     = elapsed_ms;
    snap_valid_next     = snap_valid;
    snap_blinking_next  = snap_blinking;
    snap_interval_next  = snap_interval;
    snap_color_next     = snap_color;
    send                = 1'b0;
    send_color          = '0;
    case (cmd_t'(command))
      CMD_SOLID: begin
        blink_active_next = 1'b0;
        solid_color_next  = in_color;
        send              = 1'b1;
        send_color        = in_color;
      end
      CMD_BLINK_START: begin
        snap_blinking_next = blink_active;
        if (blink_active) begin
          snap_interval_next = flash_interval;
          snap_color_next    = flash_color;
        end else begin
          snap_color_next    = solid_color;
        end
        snap_valid_next     = 1'b1;
        flash_interval_next = blink_interval;
        flash_color_next    = in_color;
        elapsed_ms_next     = '0;
        phase_on_next       = 1'b0;
        blink_active_next   = 1'b1;
        send                = 1'b1;
      end
      CMD_BLINK_END: begin
        blink_active_next = 1'b0;
        if (snap_valid) begin
          send = 1'b1;
          if (snap_blinking) begin
            flash_interval_next = snap_interval;
            flash_color_next    = snap_color;
            elapsed_ms_next     = '0;
            phase_on_next       = 1'b0;
            blink_active_next   = 1'b1;
          end else begin
            solid_color_next = snap_color;
            send_color       = snap_color;
          end
        end
      end
      CMD_TICK: begin
        if (blink_active) begin
          if (elapsed_inc >= flash_interval) begin
            elapsed_ms_next = '0;
            phase_on_next   = ~phase_on;
            send            = 1'b1;
            send_color      = phase_on ? '0 : flash_color;
          end else begin
            elapsed_ms_next = elapsed_inc;
          end
        end
      end
      default: begin
        send = 1'b0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_active   <= 1'b0;
      phase_on       <= 1'b0;
      solid_color    <= '0;
      flash_color    <= '0;
      flash_interval <= '0;
      elapsed_ms     <= '0;
      snap_valid     <= 1'b0;
      snap_blinking  <= 1'b0;
      snap_interval  <= '0;
      snap_color     <= '0;
    end else if (accept) begin
      blink_active   <= blink_active_next;
      phase_on       <= phase_on_next;
      solid_color    <= solid_color_next;
      flash_color    <= flash_color_next;
      flash_interval <= flash_interval_next;
      elapsed_ms     <= elapsed_ms_next;
      snap_valid     <= snap_valid_next;
      snap_blinking  <= snap_blinking_next;
      snap_interval  <= snap_interval_next;
      snap_color     <= snap_color_next;
    end
  end

  // frame request toward the queue
  assign frame_req.valid = accept & send;
  assign frame_req.grb   = rgb_to_grb(send_color);

endmodule

>>> hw/rtl/slbe_frame_queue.sv
// ----------------------------------------------------------------------------
// slbe_frame_queue
// Short queue of pending frame colors between the command front and the
// symbol serializer.
// ----------------------------------------------------------------------------
module slbe_frame_queue import slbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  frame_req_t wr_req,
  output logic       full,
  input  logic       rd_en,
  output logic       rd_avail,
  output color_t     rd_grb
);

  color_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wr_ptr;
  logic [QUEUE_AW-1:0]    rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_wr;
  logic                   do_rd;

  assign full     = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign rd_avail = (count != '0);
  assign rd_grb   = slots[rd_ptr];
  assign do_wr    = wr_req.valid & ~full;
  assign do_rd    = rd_en & rd_avail;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (do_rd) rd_ptr <= rd_ptr + QUEUE_AW'(1);
      case ({do_wr, do_rd})
        2'b10:   count <= count + QUEUE_CNT_W'(1);
        2'b01:   count <= count - QUEUE_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_req.grb;
  end

endmodule

>>> hw/rtl/slbe_back.sv
// ----------------------------------------------------------------------------
// slbe_back
// Symbol serializer: shifts a frame out one bit symbol per cycle into the
// result register while free, using the pulse-length configuration registers.
// ----------------------------------------------------------------------------
module slbe_back import slbe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [PULSE_W-1:0]     cfg_data,
  input  logic                   q_avail,
  input  color_t                 q_grb,
  output logic                   q_pop,
  input  logic                   pop,
  output logic                   empty,
  output logic [PULSE_W-1:0]     high_ticks,
  output logic [PULSE_W-1:0]     low_ticks,
  output logic                   bit_value,
  output logic                   last_symbol
);

  logic [PULSE_W-1:0]   long_pulse;
  logic [PULSE_W-1:0]   short_pulse;
  logic [PULSE_W-1:0]   long_eff;
  logic [PULSE_W-1:0]   short_eff;
  color_t               shift;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic                 busy;
  logic                 out_valid;
  logic                 slot_free;
  logic                 emit;
  logic                 at_last;

  // pulse-length registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_pulse  <= LONG_PULSE_RESET;
      short_pulse <= SHORT_PULSE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_LONG_PULSE)  long_pulse  <= cfg_data;
      if (cfg_index == REG_SHORT_PULSE) short_pulse <= cfg_data;
    end
  end

  assign long_eff  = clamp_pulse(long_pulse);
  assign short_eff = clamp_pulse(short_pulse);
  assign slot_free = ~out_valid | pop;
  assign emit      = busy & slot_free;
  assign at_last   = (bit_cnt == BIT_CNT_W'(BITS_PER_FRAME - 1));
  assign q_pop     = q_avail & (~busy | (emit & at_last));

  // shift register and bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (q_pop) begin
      busy    <= 1'b1;
      bit_cnt <= '0;
    end else if (emit) begin
      busy    <= ~at_last;
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      shift <= q_grb;
    end else if (emit) begin
      shift <= {shift[BITS_PER_FRAME-2:0], 1'b0};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bit_value   <= shift[BITS_PER_FRAME-1];
      high_ticks  <= shift[BITS_PER_FRAME-1] ? long_eff : short_eff;
      low_ticks   <= shift[BITS_PER_FRAME-1] ? short_eff : long_eff;
      last_symbol <= at_last;
    end
  end

  assign empty = ~out_valid;

endmodule

>>> hw/rtl/status_led_blink_encoder.sv
// ----------------------------------------------------------------------------
// status_led_blink_encoder
// Status LED controller producing WS2812-style bit symbols with blink.
// ----------------------------------------------------------------------------
// Commands are taken one per cycle while full is low; a set solid, blink
// start, replaying blink end or toggling tick queues one frame of 24 symbols
// (green, red, blue, msb first), other commands produce nothing. A two-entry
// frame queue separates the command decoder from the serializer, which puts
// out one symbol per cycle while pop is held, so the serializer sets the
// pace of frame-sending commands. The pulse registers are read as symbols
// are formed, so write them only while the block is idle; a pulse setting
// of zero is sent as one tick. cfg_ready is always high.
// ----------------------------------------------------------------------------
module status_led_blink_encoder import slbe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // command queue side
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             command,
  input  logic [7:0]             red,
  input  logic [7:0]             green,
  input  logic [7:0]             blue,
  input  logic [INTERVAL_W-1:0]  blink_interval,
  // symbol queue side
  output logic                   empty,
  input  logic                   pop,
  output logic [PULSE_W-1:0]     high_ticks,
  output logic [PULSE_W-1:0]     low_ticks,
  output logic                   bit_value,
  output logic                   last_symbol,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [PULSE_W-1:0]     cfg_data
);

  frame_req_t frame_req;
  logic       accept;
  logic       q_avail;
  logic       q_pop;
  color_t     q_grb;

  assign accept    = push & ~full;
  assign cfg_ready = 1'b1;

  // command decoder
  slbe_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .command        (command),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .blink_interval (blink_interval),
    .frame_req      (frame_req)
  );

  // pending frames
  slbe_frame_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_req   (frame_req),
    .full     (full),
    .rd_en    (q_pop),
    .rd_avail (q_avail),
    .rd_grb   (q_grb)
  );

  // symbol serializer
  slbe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_avail     (q_avail),
    .q_grb       (q_grb),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .high_ticks  (high_ticks),
    .low_ticks   (low_ticks),
    .bit_value   (bit_value),
    .last_symbol (last_symbol)
  );

endmodule

>>> hw/rtl/slbe_checker.sv
// ----------------------------------------------------------------------------
// slbe_checker
// Port-level checks on the status LED encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "status_led_blink_encoder_macros.svh"

module slbe_checker import slbe_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic [PULSE_W-1:0] high_ticks,
  input logic [PULSE_W-1:0] low_ticks,
  input logic               bit_value,
  input logic               last_symbol
);

  // a stalled symbol stays put
  `SLBE_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(high_ticks) && $stable(low_ticks) && $stable(bit_value) && $stable(last_symbol), "symbol changed while stalled")

  // every symbol half lasts at least one tick
  `SLBE_ASSERT_NOW(a_nonzero, !empty, high_ticks != '0 && low_ticks != '0, "zero-length pulse half")

  // nothing waits right after reset
  `SLBE_ASSERT_NOW(a_reset_empty, $past(rst), empty, "result present after reset")

endmodule

bind status_led_blink_encoder slbe_checker u_slbe_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .high_ticks  (high_ticks),
  .low_ticks   (low_ticks),
  .bit_value   (bit_value),
  .last_symbol (last_symbol)
);

>>> tb/sv/tb_status_led_blink_encoder.sv
// ----------------------------------------------------------------------------
// tb_status_led_blink_encoder
// Self-checking bench for the status LED blink encoder.
// ----------------------------------------------------------------------------
// Drives commands through the push/full side in random bursts and drains
// symbols through the empty/pop side with its own stall patterns. A tracker
// object keeps a private copy of the controller state and pulse settings,
// expands every accepted request into its expected symbols, and compares
// each popped symbol field by field. Pulse settings change between phases
// only once the block has drained.
// ----------------------------------------------------------------------------
module tb_status_led_blink_encoder import slbe_pkg::*; ();

  localparam int          ITEMS_PER_PHASE = 56;
  localparam int          NUM_PHASES      = 6;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          HOLD_CYCLES     = 400;
  localparam int unsigned CYCLE_LIMIT     = 600000;

  typedef struct packed {
    logic [PULSE_W-1:0] hi;
    logic [PULSE_W-1:0] lo;
    logic               bitv;
    logic               last;
  } symbol_t;

  typedef struct packed {
    cmd_t                  cmd;
    color_t                rgb;
    logic [INTERVAL_W-1:0] ms;
  } request_t;

  typedef enum logic [1:0] {
    SINK_STEADY,
    SINK_COIN,
    SINK_PERIODIC,
    SINK_SPARSE
  } sink_mode_t;

  // expected symbol stream of the LED controller
  class led_symbol_tracker;
    logic [PULSE_W-1:0]    long_ticks  = LONG_PULSE_RESET;
    logic [PULSE_W-1:0]    short_ticks = SHORT_PULSE_RESET;
    bit                    blink_on;
    bit                    phase_lit;
    bit                    snap_ok;
    bit                    snap_blink;
    color_t                solid_rgb;
    color_t                flash_rgb;
    color_t                snap_rgb;
    logic [INTERVAL_W-1:0] flash_ms;
    logic [INTERVAL_W-1:0] elapsed;
    logic [INTERVAL_W-1:0] snap_ms;
    symbol_t               pending_symbols[$];
    int                    mismatches;

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [PULSE_W-1:0] data);
      if (idx == REG_LONG_PULSE) long_ticks = data;
      else if (idx == REG_SHORT_PULSE) short_ticks = data;
    endfunction

    // one frame: green, red, blue, msb first
    function void queue_frame(color_t rgb);
      logic [23:0]        grb;
      logic [PULSE_W-1:0] lng;
      logic [PULSE_W-1:0] sht;
      symbol_t            s;
      grb = {rgb[15:8], rgb[23:16], rgb[7:0]};
      lng = (long_ticks == '0) ? PULSE_W'(1) : long_ticks;
      sht = (short_ticks == '0) ? PULSE_W'(1) : short_ticks;
      for (int k = 0; k < BITS_PER_FRAME; k++) begin
        s.bitv = grb[BITS_PER_FRAME-1-k];
        s.hi   = s.bitv ? lng : sht;
        s.lo   = s.bitv ? sht : lng;
        s.last = (k == BITS_PER_FRAME - 1);
        pending_symbols.push_back(s);
      end
    endfunction

    function void show_solid(color_t rgb);
      blink_on  = 1'b0;
      solid_rgb = rgb;
      queue_frame(rgb);
    endfunction

    // blink always restarts on an off frame
    function void start_flash(logic [INTERVAL_W-1:0] ms, color_t rgb);
      flash_ms  = ms;
      flash_rgb = rgb;
      elapsed   = '0;
      phase_lit = 1'b0;
      blink_on  = 1'b1;
      queue_frame('0);
    endfunction

    // accepted request
    function void take_command(request_t rq);
      case (rq.cmd)
        CMD_SOLID: show_solid(rq.rgb);
        CMD_BLINK_START: begin
          snap_blink = blink_on;
          if (blink_on) begin
            snap_ms  = flash_ms;
            snap_rgb = flash_rgb;
          end else begin
            snap_rgb = solid_rgb;
          end
          snap_ok = 1'b1;
          start_flash(rq.ms, rq.rgb);
        end
        CMD_BLINK_END: begin
          blink_on = 1'b0;
          if (snap_ok) begin
            if (snap_blink) start_flash(snap_ms, snap_rgb);
            else show_solid(snap_rgb);
          end
        end
        default: begin
          if (blink_on) begin
            if (elapsed != '1) elapsed++;
            if (elapsed >= flash_ms) begin
              elapsed   = '0;
              phase_lit = !phase_lit;
              queue_frame(phase_lit ? flash_rgb : color_t'(0));
            end
          end
        end
      endcase
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // accepted symbol against the oldest expectation
    function void match_symbol(logic [PULSE_W-1:0] hi, logic [PULSE_W-1:0] lo,
                               logic bitv, logic last);
      symbol_t want;
      if (pending_symbols.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected symbol, expected none, actual hi=%0d lo=%0d bit=%0b last=%0b",
                 $time, hi, lo, bitv, last);
        return;
      end
      want = pending_symbols.pop_front();
      check_field("high_ticks", want.hi, hi);
      check_field("low_ticks", want.lo, lo);
      check_field("bit_value", want.bitv, bitv);
      check_field("last_symbol", want.last, last);
    endfunction
  endclass

  logic                   clk;
  logic                   rst            = 1'b1;
  logic                   push           = 1'b0;
  logic                   full;
  logic [1:0]             command        = '0;
  logic [7:0]             red            = '0;
  logic [7:0]             green          = '0;
  logic [7:0]             blue           = '0;
  logic [INTERVAL_W-1:0]  blink_interval = '0;
  logic                   empty;
  logic                   pop            = 1'b0;
  logic [PULSE_W-1:0]     high_ticks;
  logic [PULSE_W-1:0]     low_ticks;
  logic                   bit_value;
  logic                   last_symbol;
  logic                   cfg_valid      = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index      = '0;
  logic [PULSE_W-1:0]     cfg_data       = '0;
  logic                   hold_off_req   = 1'b0;

  led_symbol_tracker tracker = new;

  status_led_blink_encoder u_dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // symbol sink with changing stall patterns and one long hold-off
  initial begin : symbol_sink
    sink_mode_t mode;
    int         seg_left;
    int         hold_left;
    bit         hold_done;
    logic       next_pop;
    mode      = SINK_STEADY;
    seg_left  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty)
        tracker.match_symbol(high_ticks, low_ticks, bit_value, last_symbol);
      if (seg_left == 0) begin
        mode     = sink_mode_t'($urandom_range(3, 0));
        seg_left = $urandom_range(200, 20);
      end
      seg_left--;
      if (hold_off_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      case (mode)
        SINK_STEADY:   next_pop = 1'b1;
        SINK_COIN:     next_pop = ($urandom_range(1, 0) == 1);
        SINK_PERIODIC: next_pop = (seg_left % 3) == 0;
        default:       next_pop = ($urandom_range(7, 0) == 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        next_pop = 1'b0;
      end
      pop <= next_pop;
    end
  end

  function automatic request_t mk_request(cmd_t c, color_t rgb, logic [INTERVAL_W-1:0] ms);
    request_t rq;
    rq.cmd = c;
    rq.rgb = rgb;
    rq.ms  = ms;
    return rq;
  endfunction

  // send requests in bursts, push stays high across a zero gap
  task automatic drive_items(input request_t items[$]);
    int idx;
    int burst;
    int gap;
    idx = 0;
    while (idx < items.size()) begin
      burst = $urandom_range(12, 1);
      push <= 1'b1;
      while (burst > 0 && idx < items.size()) begin
        command        <= items[idx].cmd;
        red            <= items[idx].rgb[23:16];
        green          <= items[idx].rgb[15:8];
        blue           <= items[idx].rgb[7:0];
        blink_interval <= items[idx].ms;
        do @(posedge clk); while (full);
        tracker.take_command(items[idx]);
        idx++;
        burst--;
      end
      if (idx == items.size()) begin
        push <= 1'b0;
      end else begin
        gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // single register write, valid left high for a following write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [PULSE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
  endtask

  // all symbols back, then let silent commands finish
  task automatic wait_drained();
    while (tracker.pending_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // main sequence
  initial begin : stimulus
    request_t           items[$];
    logic [PULSE_W-1:0] long_plan[NUM_PHASES];
    logic [PULSE_W-1:0] short_plan[NUM_PHASES];
    int                 pick;
    cmd_t               c;
    color_t             rgb;
    logic [INTERVAL_W-1:0] ms;
    long_plan  = '{4'd15, 4'd0, 4'd1, 4'd15, 4'd0, 4'd0};
    short_plan = '{4'd1, 4'd0, 4'd15, 4'd15, 4'd0, 4'd0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed requests at the reset pulse settings
    items.push_back(mk_request(CMD_BLINK_END, 24'h123456, 16'h0001));   // no snapshot yet
    items.push_back(mk_request(CMD_TICK, 24'hFFFFFF, 16'hFFFF));        // idle tick
    items.push_back(mk_request(CMD_SOLID, 24'h000000, 16'h0000));
    items.push_back(mk_request(CMD_SOLID, 24'hFFFFFF, 16'hFFFF));
    items.push_back(mk_request(CMD_SOLID, 24'hAA550F, 16'h5A5A));
    items.push_back(mk_request(CMD_BLINK_START, 24'h123456, 16'h0000)); // zero interval
    items.push_back(mk_request(CMD_TICK, 24'h000000, 16'h0000));
    items.push_back(mk_request(CMD_TICK, 24'h000000, 16'h0000));
    items.push_back(mk_request(CMD_BLINK_START, 24'hFEDCBA, 16'h0002)); // snapshot of a blink
    items.push_back(mk_request(CMD_TICK, 24'h000000, 16'h0000));
    items.push_back(mk_request(CMD_TICK, 24'h000000, 16'h0000));
    items.push_back(mk_request(CMD_BLINK_END, 24'h000000, 16'h0000));   // blink replay
    items.push_back(mk_request(CMD_TICK, 24'h000000, 16'h0000));
    items.push_back(mk_request(CMD_BLINK_END, 24'hFFFFFF, 16'hFFFF));   // replay again
    items.push_back(mk_request(CMD_SOLID, 24'h3CC381, 16'h0000));
    items.push_back(mk_request(CMD_BLINK_START, 24'hFFFFFF, 16'hFFFF)); // snapshot of solid
    items.push_back(mk_request(CMD_TICK, 24'h000000, 16'h0000));
    items.push_back(mk_request(CMD_BLINK_END, 24'h000000, 16'h0000));   // solid replay
    items.push_back(mk_request(CMD_TICK, 24'h000000, 16'h0000));
    items.push_back(mk_request(CMD_BLINK_START, 24'h0180FF, 16'h0001));
    items.push_back(mk_request(CMD_TICK, 24'h000000, 16'h0000));
    items.push_back(mk_request(CMD_TICK, 24'h000000, 16'h0000));
    items.push_back(mk_request(CMD_BLINK_END, 24'h000000, 16'h0000));
    drive_items(items);
    wait_drained();

    // random phases, each under its own pulse settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph >= 4) begin
        long_plan[ph]  = PULSE_W'($urandom_range(15, 0));
        short_plan[ph] = PULSE_W'($urandom_range(15, 0));
      end
      write_reg(REG_LONG_PULSE, long_plan[ph]);
      write_reg(REG_SHORT_PULSE, short_plan[ph]);
      // index past the register list is dropped
      write_reg(CFG_INDEX_W'($urandom_range((1 << CFG_INDEX_W) - 1, REG_SHORT_PULSE + 1)),
                PULSE_W'($urandom_range(15, 0)));
      cfg_valid <= 1'b0;
      if (ph == 2) hold_off_req <= 1'b1;

      items.delete();
      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(99, 0);
        if (pick < 12) c = CMD_SOLID;
        else if (pick < 26) c = CMD_BLINK_START;
        else if (pick < 42) c = CMD_BLINK_END;
        else c = CMD_TICK;
        pick = $urandom_range(99, 0);
        if (pick < 8) rgb = '0;
        else if (pick < 16) rgb = '1;
        else rgb = color_t'($urandom);
        pick = $urandom_range(99, 0);
        if (pick < 65) ms = INTERVAL_W'($urandom_range(3, 0));
        else if (pick < 85) ms = INTERVAL_W'($urandom_range(40, 0));
        else ms = INTERVAL_W'($urandom_range(65535, 0));
        items.push_back(mk_request(c, rgb, ms));
      end
      drive_items(items);
      wait_drained();
    end

    if (tracker.mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/slbe_pkg.sv
hw/rtl/slbe_front.sv
hw/rtl/slbe_frame_queue.sv
hw/rtl/slbe_back.sv
hw/rtl/status_led_blink_encoder.sv
hw/rtl/slbe_checker.sv
tb/sv/tb_status_led_blink_encoder.sv
